@@ sv/wsad_pkg.sv @@
// Shared constants and types for the weighted SAD best-match search block.
package wsad_pkg;

  localparam int LANES_DEF    = 8;
  localparam int SUM_BITS_DEF = 48;
  localparam int POS_BITS_DEF = 24;

  // Each item carries eight packed bytes per spectrum
  localparam int LANE_WORD_BITS = 64;
  localparam int WORD_LANES     = 8;
  localparam int WEIGHT_BIAS    = 129;

  localparam int RECHECK_BITS = 20;
  localparam int WINDOW_BITS  = 16;
  localparam logic [RECHECK_BITS-1:0] RECHECK_RESET = RECHECK_BITS'(100);
  localparam logic [WINDOW_BITS-1:0]  WINDOW_RESET  = WINDOW_BITS'(16);

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // Register select, taken from the word address bit
  typedef enum logic {
    REG_RECHECK = 1'b0,
    REG_WINDOW  = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic frame_end;
    logic candidate_end;
    logic search_start;
  } item_ctl_t;

endpackage

@@ sv/wsad_in_if.sv @@
// Input channel: reference and candidate lane groups with framing marks.
interface wsad_in_if #(
  parameter int POS_BITS = wsad_pkg::POS_BITS_DEF
);
  import wsad_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [LANE_WORD_BITS-1:0] ref_lanes;
  logic [LANE_WORD_BITS-1:0] cand_lanes;
  logic                      frame_end;
  logic                      candidate_end;
  logic [POS_BITS-1:0]       candidate_pos;
  logic                      search_start;

  modport source (
    output valid, ref_lanes, cand_lanes, frame_end, candidate_end, candidate_pos,
           search_start,
    input  ready
  );

  modport sink (
    input  valid, ref_lanes, cand_lanes, frame_end, candidate_end, candidate_pos,
           search_start,
    output ready
  );

endinterface

@@ sv/wsad_out_if.sv @@
// Result channel: candidate sum, best match so far and the done flag.
interface wsad_out_if #(
  parameter int SUM_BITS = wsad_pkg::SUM_BITS_DEF,
  parameter int POS_BITS = wsad_pkg::POS_BITS_DEF
);

  logic                valid;
  logic                ready;
  logic [SUM_BITS-1:0] candidate_sum;
  logic [SUM_BITS-1:0] best_sum;
  logic [POS_BITS-1:0] best_pos;
  logic                search_done;

  modport source (
    output valid, candidate_sum, best_sum, best_pos, search_done,
    input  ready
  );

  modport sink (
    input  valid, candidate_sum, best_sum, best_pos, search_done,
    output ready
  );

endinterface

@@ sv/wsad_group_sum.sv @@
// Weighted absolute difference of one lane group, summed over the lanes.
module wsad_group_sum #(
  parameter int LANES   = wsad_pkg::LANES_DEF,
  parameter int GS_BITS = 20
) (
  input  logic [wsad_pkg::LANE_WORD_BITS-1:0] ref_lanes,
  input  logic [wsad_pkg::LANE_WORD_BITS-1:0] cand_lanes,
  output logic [GS_BITS-1:0]                  group_sum
);
  import wsad_pkg::*;

  localparam int ActLanes = (LANES < WORD_LANES) ? LANES : WORD_LANES;

  logic [16:0] lane_prod [ActLanes];

  // |ref - cand| is at most 255, the weight ref + 129 lies in 1..256
  always_comb begin
    logic signed [8:0] r;
    logic signed [8:0] c;
    logic signed [8:0] d;
    logic        [8:0] mag;
    logic        [8:0] wgt;
    for (int i = 0; i < ActLanes; i++) begin
      r   = 9'(signed'(ref_lanes[8*i +: 8]));
      c   = 9'(signed'(cand_lanes[8*i +: 8]));
      d   = r - c;
      mag = d[8] ? 9'(-d) : 9'(d);
      wgt = 9'(r + 9'sd129);
      lane_prod[i] = 17'(mag[7:0] * wgt);
    end
  end

  always_comb begin
    group_sum = '0;
    for (int i = 0; i < ActLanes; i++) begin
      group_sum = group_sum + GS_BITS'(lane_prod[i]);
    end
  end

endmodule

@@ sv/weighted_sad_best_match_search_top.sv @@
// Weighted SAD best-match search. One lane group is taken per clock while the
// result channel does not hold back a candidate end; an item passes an input
// register, a stage that forms the weighted lane sum, and a stage that folds
// it into the running sum and the best-match state, which writes a candidate
// end into the result register. The rate rests on the combinational running-sum
// update (one 48-bit saturating add followed by the compare against the best
// sum). An item that produces no result never waits at the fold stage; a
// candidate end waits only while the result register is full.
module weighted_sad_best_match_search_top #(
  parameter int LANES    = wsad_pkg::LANES_DEF,
  parameter int SUM_BITS = wsad_pkg::SUM_BITS_DEF,
  parameter int POS_BITS = wsad_pkg::POS_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wsad_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [wsad_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [wsad_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  wsad_in_if.sink                            item,
  wsad_out_if.source                         result
);
  import wsad_pkg::*;

  localparam int ActLanes = (LANES < WORD_LANES) ? LANES : WORD_LANES;
  localparam int GsBits   = 17 + $clog2(ActLanes);
  localparam int CmpBits  = (POS_BITS > WINDOW_BITS) ? POS_BITS : WINDOW_BITS;
  localparam logic [SUM_BITS-1:0] SumMax = {SUM_BITS{1'b1}};

  // Configuration registers
  logic [RECHECK_BITS-1:0] recheck_count;
  logic [WINDOW_BITS-1:0]  check_window;
  reg_sel_t                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_sel_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      recheck_count <= RECHECK_RESET;
      check_window  <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_RECHECK: recheck_count <= pwdata[RECHECK_BITS-1:0];
        REG_WINDOW:  check_window  <= pwdata[WINDOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RECHECK: prdata = APB_DATA_BITS'(recheck_count);
      REG_WINDOW:  prdata = APB_DATA_BITS'(check_window);
      default:     prdata = '0;
    endcase
  end

  // Stage 1: input register
  logic                      s1_valid;
  logic [LANE_WORD_BITS-1:0] s1_ref;
  logic [LANE_WORD_BITS-1:0] s1_cand;
  item_ctl_t                 s1_ctl;
  logic [POS_BITS-1:0]       s1_pos;

  // Stage 2: group sum register
  logic                s2_valid;
  logic [GsBits-1:0]   s2_gsum;
  item_ctl_t           s2_ctl;
  logic [POS_BITS-1:0] s2_pos;

  logic [GsBits-1:0] gsum;
  logic              s1_fire;
  logic              s2_take;
  logic              s2_fire;
  logic              out_free;

  // Search state
  logic [SUM_BITS-1:0]     running_sum;
  logic                    abandoned;
  logic [SUM_BITS-1:0]     best_sum;
  logic [POS_BITS-1:0]     best_pos;
  logic [RECHECK_BITS-1:0] countdown;
  logic                    done_flag;

  logic [SUM_BITS-1:0]     running_sum_next;
  logic                    abandoned_next;
  logic [SUM_BITS-1:0]     best_sum_next;
  logic [POS_BITS-1:0]     best_pos_next;
  logic [RECHECK_BITS-1:0] countdown_next;
  logic                    done_flag_next;
  logic [SUM_BITS-1:0]     cand_sum;
  logic                    emit;

  assign out_free   = !result.valid || result.ready;
  assign s2_fire    = s2_valid && (!emit || out_free);
  assign s2_take    = !s2_valid || s2_fire;
  assign s1_fire    = s1_valid && s2_take;
  assign item.ready = !s1_valid || s2_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_ref  <= item.ref_lanes;
      s1_cand <= item.cand_lanes;
      s1_ctl  <= '{frame_end:     item.frame_end,
                   candidate_end: item.candidate_end,
                   search_start:  item.search_start};
      s1_pos  <= item.candidate_pos;
    end
  end

  wsad_group_sum #(
    .LANES   (LANES),
    .GS_BITS (GsBits)
  ) u_group_sum (
    .ref_lanes  (s1_ref),
    .cand_lanes (s1_cand),
    .group_sum  (gsum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_take) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_gsum <= gsum;
      s2_ctl  <= s1_ctl;
      s2_pos  <= s1_pos;
    end
  end

  // Stage 3: fold the group into the search state
  always_comb begin
    logic [SUM_BITS-1:0]     rs_e;
    logic                    ab_e;
    logic [SUM_BITS-1:0]     bs_e;
    logic [POS_BITS-1:0]     bp_e;
    logic [RECHECK_BITS-1:0] cd_e;
    logic                    dn_e;
    logic [SUM_BITS:0]       sum_ext;
    logic [SUM_BITS-1:0]     rs_add;
    logic                    ab_add;
    logic                    improve;
    logic [POS_BITS-1:0]     pos_gap;
    logic [RECHECK_BITS-1:0] cd_dec;

    // A search start resets the state before the item is taken in
    rs_e = s2_ctl.search_start ? '0 : running_sum;
    ab_e = s2_ctl.search_start ? 1'b0 : abandoned;
    bs_e = s2_ctl.search_start ? SumMax : best_sum;
    bp_e = s2_ctl.search_start ? '0 : best_pos;
    cd_e = s2_ctl.search_start ? recheck_count : countdown;
    dn_e = s2_ctl.search_start ? (recheck_count == '0) : done_flag;

    sum_ext = {1'b0, rs_e} + (SUM_BITS+1)'(s2_gsum);
    rs_add  = ab_e ? rs_e : (sum_ext[SUM_BITS] ? SumMax : sum_ext[SUM_BITS-1:0]);
    ab_add  = ab_e || (s2_ctl.frame_end && (rs_add > bs_e));
    improve = rs_add < bs_e;

    pos_gap = (s2_pos > bp_e) ? (s2_pos - bp_e) : (bp_e - s2_pos);
    cd_dec  = ((CmpBits'(pos_gap) <= CmpBits'(check_window)) && (cd_e != '0)) ?
              (cd_e - 1'b1) : cd_e;

    cand_sum         = rs_add;
    emit             = !dn_e && s2_ctl.candidate_end;
    running_sum_next = rs_e;
    abandoned_next   = ab_e;
    best_sum_next    = bs_e;
    best_pos_next    = bp_e;
    countdown_next   = cd_e;
    done_flag_next   = dn_e;

    if (!dn_e) begin
      if (!s2_ctl.candidate_end) begin
        running_sum_next = rs_add;
        abandoned_next   = ab_add;
      end else begin
        running_sum_next = '0;
        abandoned_next   = 1'b0;
        if (improve) begin
          best_sum_next  = rs_add;
          best_pos_next  = s2_pos;
          countdown_next = recheck_count;
        end else begin
          countdown_next = cd_dec;
        end
        done_flag_next = (countdown_next == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      abandoned   <= 1'b0;
      best_sum    <= SumMax;
      best_pos    <= '0;
      countdown   <= RECHECK_RESET;
      done_flag   <= 1'b0;
    end else if (s2_fire) begin
      running_sum <= running_sum_next;
      abandoned   <= abandoned_next;
      best_sum    <= best_sum_next;
      best_pos    <= best_pos_next;
      countdown   <= countdown_next;
      done_flag   <= done_flag_next;
    end
  end

  // Result register; the candidate sum is the pre-clear running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s2_fire && emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && emit) begin
      result.candidate_sum <= cand_sum;
      result.best_sum      <= best_sum_next;
      result.best_pos      <= best_pos_next;
      result.search_done   <= done_flag_next;
    end
  end

`ifndef ASSERT_OFF
  a_emit_fills_result: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && emit) |=> result.valid)
    else $error("candidate end processed without a result");

  a_best_never_rises: assert property (@(posedge clk) disable iff (rst)
    !(s2_fire && s2_ctl.search_start) |=> (best_sum <= $past(best_sum)))
    else $error("best sum rose without a search start");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (s1_valid && s2_valid))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

@@ sim/weighted_sad_best_match_search_top_tb.sv @@
// Testbench for the weighted SAD best-match search block, self-checking against its own predictor.
`timescale 1ns / 100ps

module weighted_sad_best_match_search_top_tb;
  import wsad_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS = 242;

  typedef struct {
    logic [LANE_WORD_BITS-1:0] ref_word;
    logic [LANE_WORD_BITS-1:0] cand_word;
    logic                      fend;
    logic                      cend;
    logic [POS_BITS_DEF-1:0]   pos;
    logic                      start;
  } lane_item_t;

  typedef struct {
    logic [SUM_BITS_DEF-1:0] cand_sum;
    logic [SUM_BITS_DEF-1:0] best_sum;
    logic [POS_BITS_DEF-1:0] best_pos;
    logic                    done;
  } match_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  wsad_in_if  #(.POS_BITS(POS_BITS_DEF)) in_ch ();
  wsad_out_if #(.SUM_BITS(SUM_BITS_DEF), .POS_BITS(POS_BITS_DEF)) out_ch ();

  weighted_sad_best_match_search_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (in_ch),
    .result  (out_ch)
  );

  // Register copies and search state as the block should hold them after reset
  logic [RECHECK_BITS-1:0] cfg_recheck = RECHECK_RESET;
  logic [WINDOW_BITS-1:0]  cfg_window  = WINDOW_RESET;
  logic [SUM_BITS_DEF-1:0] acc_sum = '0;
  logic                    acc_cut = 1'b0;
  logic [SUM_BITS_DEF-1:0] track_best_sum = '1;
  logic [POS_BITS_DEF-1:0] track_best_pos = '0;
  logic [RECHECK_BITS-1:0] track_count = RECHECK_RESET;
  logic                    track_done = 1'b0;

  match_t pending_matches[$];

  bit src_idle = 1'b0;
  bit snk_idle = 1'b0;
  int cycle_cnt = 0;
  int n_taken = 0;
  int n_ignored = 0;
  int n_improve = 0;
  int n_abandon = 0;
  int n_finished = 0;
  int n_checked = 0;
  int n_errors = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [SUM_BITS_DEF-1:0] weighted_diff(logic [LANE_WORD_BITS-1:0] rw,
                                                            logic [LANE_WORD_BITS-1:0] cw);
    logic [SUM_BITS_DEF-1:0] acc;
    byte rb;
    byte cb;
    int d;
    acc = '0;
    for (int i = 0; i < WORD_LANES; i++) begin
      rb = rw[8*i +: 8];
      cb = cw[8*i +: 8];
      d = int'(rb) - int'(cb);
      if (d < 0) d = -d;
      acc += SUM_BITS_DEF'(d * (int'(rb) + WEIGHT_BIAS));
    end
    return acc;
  endfunction

  function automatic logic [SUM_BITS_DEF-1:0] sat_add(logic [SUM_BITS_DEF-1:0] a,
                                                      logic [SUM_BITS_DEF-1:0] b);
    logic [SUM_BITS_DEF:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_BITS_DEF] ? {SUM_BITS_DEF{1'b1}} : s[SUM_BITS_DEF-1:0];
  endfunction

  // Advance the predicted state by one transferred item; queue a match on a candidate end while not done
  function automatic void fold_item(lane_item_t it);
    match_t m;
    logic [POS_BITS_DEF-1:0] pos_gap;
    if (it.start) begin
      track_best_sum = '1;
      track_best_pos = '0;
      track_count = cfg_recheck;
      acc_sum = '0;
      acc_cut = 1'b0;
      track_done = (cfg_recheck == 0);
    end
    if (track_done) begin
      n_ignored++;
      return;
    end
    n_taken++;
    if (!acc_cut) acc_sum = sat_add(acc_sum, weighted_diff(it.ref_word, it.cand_word));
    if (it.fend && !acc_cut && acc_sum > track_best_sum) begin
      acc_cut = 1'b1;
      n_abandon++;
    end
    if (!it.cend) return;
    m.cand_sum = acc_sum;
    if (acc_sum < track_best_sum) begin
      track_best_sum = acc_sum;
      track_best_pos = it.pos;
      track_count = cfg_recheck;
      n_improve++;
    end else begin
      pos_gap = (it.pos > track_best_pos) ? it.pos - track_best_pos : track_best_pos - it.pos;
      if (pos_gap <= cfg_window && track_count > 0) track_count--;
    end
    if (track_count == 0) begin
      track_done = 1'b1;
      n_finished++;
    end
    acc_sum = '0;
    acc_cut = 1'b0;
    m.best_sum = track_best_sum;
    m.best_pos = track_best_pos;
    m.done = track_done;
    pending_matches = {pending_matches, m};
  endfunction

  function automatic lane_item_t mk_item(logic [LANE_WORD_BITS-1:0] rw,
                                         logic [LANE_WORD_BITS-1:0] cw,
                                         logic fe, logic ce,
                                         logic [POS_BITS_DEF-1:0] p, logic st);
    lane_item_t it;
    it.ref_word = rw;
    it.cand_word = cw;
    it.fend = fe;
    it.cend = ce;
    it.pos = p;
    it.start = st;
    return it;
  endfunction

  // Hold valid high across back-to-back items; drop it only for a gap
  task automatic send_item(lane_item_t it);
    int gap;
    gap = src_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.ref_lanes     <= it.ref_word;
    in_ch.cand_lanes    <= it.cand_word;
    in_ch.frame_end     <= it.fend;
    in_ch.candidate_end <= it.cend;
    in_ch.candidate_pos <= it.pos;
    in_ch.search_start  <= it.start;
    do @(posedge clk); while (!in_ch.ready);
    fold_item(it);
  endtask

  task automatic write_reg(reg_sel_t sel, logic [APB_DATA_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_RECHECK) cfg_recheck = val[RECHECK_BITS-1:0];
    else cfg_window = val[WINDOW_BITS-1:0];
    @(posedge clk);
  endtask

  // Wait for every expected match, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_lane_extremes();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    send_item(mk_item({8{8'h7F}}, {8{8'h80}}, 1'b1, 1'b1, '0, 1'b1));
    send_item(mk_item({8{8'h80}}, {8{8'h7F}}, 1'b1, 1'b1, '1, 1'b0));
    send_item(mk_item('0, '0, 1'b1, 1'b1, '0, 1'b0));
    // cut short after the first frame, nothing added by the second
    send_item(mk_item('1, '0, 1'b1, 1'b0, 24'd5, 1'b0));
    send_item(mk_item('1, '0, 1'b1, 1'b1, 24'd5, 1'b0));
    // candidate end with no frame end, outside the window
    send_item(mk_item('0, '1, 1'b0, 1'b1, 24'd100, 1'b0));
  endtask

  task automatic test_early_abandon();
    logic [LANE_WORD_BITS-1:0] base;
    base = 64'h0123_4567_89AB_CDEF;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_item(mk_item(base, base ^ 64'h1, 1'b1, 1'b1, 24'd1000, 1'b1));
    for (int i = 0; i < 3; i++)
      send_item(mk_item(base, ~base, 1'b1, i == 2, 24'd1003, 1'b0));
    // first frame still below the best, second frame pushes it over
    send_item(mk_item(base, base, 1'b1, 1'b0, 24'd1010, 1'b0));
    send_item(mk_item(base, base ^ 64'h3, 1'b1, 1'b1, 24'd1010, 1'b0));
  endtask

  task automatic test_search_done();
    logic [LANE_WORD_BITS-1:0] base;
    base = 64'hFEDC_BA98_7654_3210;
    write_reg(REG_RECHECK, 32'd10);
    write_reg(REG_WINDOW, 32'd0);
    src_idle = 1'b1;
    snk_idle = 1'b0;
    send_item(mk_item(base, base, 1'b1, 1'b1, 24'd50, 1'b1));
    for (int i = 0; i < 11; i++)
      send_item(mk_item(base, base ^ 64'h100, 1'b1, 1'b1, (i == 3) ? 24'd51 : 24'd50, 1'b0));
    // countdown exhausted: this one is dropped, the next restarts the search
    send_item(mk_item(base, ~base, 1'b1, 1'b1, 24'd50, 1'b0));
    send_item(mk_item(base, base ^ 64'h1, 1'b1, 1'b1, 24'd7, 1'b1));
  endtask

  task automatic run_traffic(int n_target);
    int start_cnt;
    int loops;
    int n_frames;
    int per_frame;
    int k;
    int pick;
    int off;
    bit need_start;
    lane_item_t it;
    logic [LANE_WORD_BITS-1:0] base;
    logic [7:0] lane_m;
    logic [POS_BITS_DEF-1:0] cpos;
    start_cnt = n_taken;
    loops = 0;
    need_start = 1'b1;
    while (n_taken - start_cnt < n_target) begin
      if (loops % 40 == 0) begin
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
      end
      loops++;
      if ($urandom_range(0, 9) == 0) begin
        it = mk_item({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), POS_BITS_DEF'($urandom),
                     $urandom_range(0, 7) == 0);
        send_item(it);
      end else begin
        if (track_done && $urandom_range(0, 3) != 0) need_start = 1'b1;
        if ($urandom_range(0, 39) == 0) need_start = 1'b1;
        pick = $urandom_range(0, 9);
        off = $urandom_range(0, int'(cfg_window) + 2);
        if (pick < 6) cpos = $urandom_range(0, 1) ? POS_BITS_DEF'(track_best_pos + off) :
                                                    POS_BITS_DEF'(track_best_pos - off);
        else if (pick < 9) cpos = POS_BITS_DEF'($urandom);
        else cpos = $urandom_range(0, 1) ? '1 : '0;
        // low bits of each lane differ, so sums spread from zero upwards
        k = $urandom_range(0, 8);
        lane_m = 8'((1 << k) - 1);
        n_frames = $urandom_range(1, 3);
        for (int f = 0; f < n_frames; f++) begin
          per_frame = $urandom_range(1, 3);
          for (int j = 0; j < per_frame; j++) begin
            base = {$urandom, $urandom};
            it = mk_item(base, base ^ ({$urandom, $urandom} & {8{lane_m}}), j == per_frame - 1,
                         (f == n_frames - 1) && (j == per_frame - 1), cpos, need_start);
            if (it.cend && $urandom_range(0, 19) == 0) it.fend = 1'b0;
            need_start = 1'b0;
            send_item(it);
          end
        end
      end
    end
  endtask

  task automatic test_random_search();
    int unsigned recheck_set[6];
    int unsigned window_set[6];
    recheck_set = '{10, 1000000, 10, 1000000, 0, 100};
    window_set  = '{0, 65535, 65535, 0, 0, 16};
    recheck_set[4] = $urandom_range(10, 5000);
    window_set[4]  = $urandom_range(0, 64);
    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(REG_RECHECK, recheck_set[p]);
      write_reg(REG_WINDOW, window_set[p]);
      run_traffic(PHASE_ITEMS);
    end
  endtask

  // Result side: when snk_idle is set, stall a random number of cycles before each transfer
  initial begin : sink_ready
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = snk_idle ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin : match_check
    match_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_checked++;
      if (pending_matches.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: candidate_sum %h best_sum %h best_pos %h done %b",
                 $time, out_ch.candidate_sum, out_ch.best_sum, out_ch.best_pos,
                 out_ch.search_done);
      end else begin
        want = pending_matches.pop_front();
        if (out_ch.candidate_sum !== want.cand_sum) begin
          n_errors++;
          $display("%0t: candidate_sum expected %h actual %h", $time, want.cand_sum,
                   out_ch.candidate_sum);
        end
        if (out_ch.best_sum !== want.best_sum) begin
          n_errors++;
          $display("%0t: best_sum expected %h actual %h", $time, want.best_sum,
                   out_ch.best_sum);
        end
        if (out_ch.best_pos !== want.best_pos) begin
          n_errors++;
          $display("%0t: best_pos expected %h actual %h", $time, want.best_pos,
                   out_ch.best_pos);
        end
        if (out_ch.search_done !== want.done) begin
          n_errors++;
          $display("%0t: search_done expected %b actual %b", $time, want.done,
                   out_ch.search_done);
        end
      end
    end
  end

  initial begin
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.ref_lanes     <= '0;
    in_ch.cand_lanes    <= '0;
    in_ch.frame_end     <= 1'b0;
    in_ch.candidate_end <= 1'b0;
    in_ch.candidate_pos <= '0;
    in_ch.search_start  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_lane_extremes();
    settle();
    test_early_abandon();
    settle();
    test_search_done();
    test_random_search();
    settle();

    $display("Ran %0d lane groups (%0d dropped after a finished search), %0d results checked.",
             n_taken + n_ignored, n_ignored, n_checked);
    $display("Saw %0d best-match updates, %0d early abandons, %0d searches run down to done.",
             n_improve, n_abandon, n_finished);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
